// File: hw/rtl/mecm_pkg.sv
// shared types and constants of the microwire eeprom command master
package mecm_pkg;

	localparam int WAIT_COUNT_BITS = 16;
	localparam int CFG_WIDTH = 16;

	localparam logic REQ_COMMAND = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [2:0] OP_READ = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_ERASE = 3'd2;
	localparam logic [2:0] OP_ENABLE = 3'd3;
	localparam logic [2:0] OP_DISABLE = 3'd4;
	localparam logic [2:0] OP_ERAL = 3'd5;
	localparam logic [2:0] OP_WRAL = 3'd6;

	localparam logic CFG_FRAME_GAP = 1'b0;
	localparam logic CFG_PROGRAM_WAIT = 1'b1;

	localparam logic [15:0] FRAME_GAP_RESET = 16'd2;
	localparam logic [15:0] PROGRAM_WAIT_RESET = 16'd5;

	typedef struct packed {
		logic req_type;
		logic [2:0] opcode;
		logic [6:0] address;
		logic [7:0] write_data;
		logic serial_in;
	} req_item_t;

	typedef struct packed {
		logic chip_select;
		logic clock_pulse;
		logic serial_out;
		logic [7:0] read_data;
		logic read_valid;
		logic busy_res;
		logic command_done;
	} res_item_t;

	// classified item as it travels from front to back
	typedef struct packed {
		logic is_cmd;
		logic [2:0] opcode;
		logic [6:0] address;
		logic [7:0] write_data;
		logic serial_in;
	} work_item_t;

	typedef struct packed {
		logic valid;
		work_item_t item;
	} work_push_t;

endpackage

// File: hw/rtl/microwire_eeprom_command_master.sv
// top level of the microwire eeprom command master
// Master for a serial EEPROM in x8 mode with a Microwire interface.
// The req channel carries two kinds of item: a command (read, write, erase,
// enable, disable, erase all, write all) that is taken only while no
// sequence runs, and a tick that moves the sequence by one serial clock or
// one idle step. Each tick gives exactly one item on the res channel with
// the select, clock and data line levels for that tick, the read byte on
// the tick of the eighth read bit, and busy and done flags. Commands, a
// command that arrives while busy and the unused opcode give no result.
// The cfg port sets the gap after each frame (index 0) and the program
// wait after a program frame (index 1); write it only while idle.
// A tick passes through the front register, then the two-entry queue, then
// the result register in the sequencer. One item is taken every cycle while
// the front register can move on; the sequencer handles one item per cycle
// while the result register is empty or being read, and a command at the
// head of the queue goes ahead even while the result waits.
// Reset clears the sequence, the queue and the result register and loads
// gap 2 and wait 5. When res_ready stays low, the queue fills and req_ready
// falls; a command already at the head of the queue is still taken.
module microwire_eeprom_command_master (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input mecm_pkg::req_item_t req,
	output logic res_valid,
	input logic res_ready,
	output mecm_pkg::res_item_t res,
	input logic cfg_we,
	input logic cfg_index,
	input logic [mecm_pkg::CFG_WIDTH-1:0] cfg_wdata
);

	mecm_pkg::work_push_t push;
	logic push_ready;
	logic q_valid;
	logic q_ready;
	mecm_pkg::work_item_t q_item;

	mecm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.push(push),
		.push_ready(push_ready)
	);

	mecm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ready(push_ready),
		.pop_valid(q_valid),
		.pop_item(q_item),
		.pop_ready(q_ready)
	);

	mecm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_ready(q_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule

// File: hw/rtl/mecm_front.sv
// front stage: takes request items, drops bad opcodes, hands work to the queue
module mecm_front (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input mecm_pkg::req_item_t req,
	output mecm_pkg::work_push_t push,
	input logic push_ready
);

	logic valid_s1;
	logic keep_s1;
	mecm_pkg::work_item_t item_s1;
	logic advance;
	logic keep;

	// commands with the unused opcode never reach the sequencer
	assign keep = (req.req_type == mecm_pkg::REQ_TICK) || (req.opcode <= mecm_pkg::OP_WRAL);
	assign advance = !valid_s1 || !keep_s1 || push_ready;
	assign req_ready = advance;

	assign push.valid = valid_s1 && keep_s1;
	assign push.item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			keep_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
			keep_s1 <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid) begin
			item_s1.is_cmd <= (req.req_type == mecm_pkg::REQ_COMMAND);
			item_s1.opcode <= req.opcode;
			item_s1.address <= req.address;
			item_s1.write_data <= req.write_data;
			item_s1.serial_in <= req.serial_in;
		end
	end

endmodule

// File: hw/rtl/mecm_queue.sv
// two-entry queue between the front stage and the sequencer
module mecm_queue (
	input logic clk,
	input logic arst_n,
	input mecm_pkg::work_push_t push,
	output logic push_ready,
	output logic pop_valid,
	output mecm_pkg::work_item_t pop_item,
	input logic pop_ready
);

	mecm_pkg::work_item_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push = push.valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

// File: hw/rtl/mecm_back.sv
// sequencer: walks the frames, gaps and waits, and registers the result item
module mecm_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [mecm_pkg::CFG_WIDTH-1:0] cfg_wdata,
	input logic q_valid,
	input mecm_pkg::work_item_t q_item,
	output logic q_ready,
	output logic res_valid,
	input logic res_ready,
	output mecm_pkg::res_item_t res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_EN_FRAME,
		PH_EN_GAP,
		PH_CMD_FRAME,
		PH_RD_BITS,
		PH_CMD_GAP,
		PH_CMD_WAIT,
		PH_DS_FRAME,
		PH_DS_GAP
	} phase_t;

	localparam int WB = mecm_pkg::WAIT_COUNT_BITS;

	phase_t phase_q, phase_n, target, rphase;
	logic [2:0] op_q, op_n, sel_op;
	logic [6:0] addr_q, addr_n, sel_addr;
	logic [7:0] data_q, data_n, sel_data;
	logic [23:0] shift_q, shift_n;
	logic [4:0] bits_q, bits_n;
	logic [WB-1:0] wait_q, wait_n;
	logic [7:0] rd_q, rd_n;
	logic [15:0] frame_gap_q;
	logic [15:0] program_wait_q;
	logic res_valid_q;
	mecm_pkg::res_item_t res_q, res_n;
	logic pop, tick, enter, finish;
	logic [WB-1:0] gap_ticks, wait_ticks;
	logic gap_zero, wait_zero;

	function automatic logic is_program(input logic [2:0] op);
		return op == mecm_pkg::OP_WRITE || op == mecm_pkg::OP_ERASE ||
			op == mecm_pkg::OP_ERAL || op == mecm_pkg::OP_WRAL;
	endfunction

	function automatic phase_t next_phase(input phase_t p, input logic [2:0] op);
		phase_t n;
		unique case (p)
			PH_EN_FRAME: n = PH_EN_GAP;
			PH_EN_GAP: n = PH_CMD_FRAME;
			PH_CMD_FRAME: n = (op == mecm_pkg::OP_READ) ? PH_RD_BITS : PH_CMD_GAP;
			PH_RD_BITS: n = PH_CMD_GAP;
			PH_CMD_GAP: n = is_program(op) ? PH_CMD_WAIT : PH_IDLE;
			PH_CMD_WAIT: n = PH_DS_FRAME;
			PH_DS_FRAME: n = PH_DS_GAP;
			default: n = PH_IDLE;
		endcase
		return n;
	endfunction

	// skip gaps and waits whose length is zero
	function automatic phase_t resolve(input phase_t p, input logic gz, input logic wz,
			input logic prog);
		phase_t n;
		unique case (p)
			PH_EN_GAP: n = gz ? PH_CMD_FRAME : PH_EN_GAP;
			PH_CMD_GAP: begin
				if (!gz) begin
					n = PH_CMD_GAP;
				end else if (!prog) begin
					n = PH_IDLE;
				end else begin
					n = wz ? PH_DS_FRAME : PH_CMD_WAIT;
				end
			end
			PH_CMD_WAIT: n = wz ? PH_DS_FRAME : PH_CMD_WAIT;
			PH_DS_GAP: n = gz ? PH_IDLE : PH_DS_GAP;
			default: n = p;
		endcase
		return n;
	endfunction

	function automatic logic [23:0] cmd_frame(input logic [2:0] op, input logic [6:0] a,
			input logic [7:0] d);
		logic [23:0] f;
		unique case (op)
			mecm_pkg::OP_READ: f = {8'h03, 1'b0, a, 8'h00};
			mecm_pkg::OP_WRITE: f = {8'h02, 1'b1, a, d};
			mecm_pkg::OP_ERASE: f = {8'h03, 1'b1, a, 8'h00};
			mecm_pkg::OP_ENABLE: f = {8'h02, 8'h60, 8'h00};
			mecm_pkg::OP_DISABLE: f = {8'h02, 8'h00, 8'h00};
			mecm_pkg::OP_ERAL: f = {8'h02, 8'h40, 8'h00};
			default: f = {8'h02, 8'h20, d};
		endcase
		return f;
	endfunction

	assign gap_ticks = WB'(frame_gap_q);
	assign wait_ticks = WB'(program_wait_q);
	assign gap_zero = (gap_ticks == '0);
	assign wait_zero = (wait_ticks == '0);

	// commands carry no result, so they go ahead even while the result waits
	assign pop = q_valid && (q_item.is_cmd || !res_valid_q || res_ready);
	assign tick = pop && !q_item.is_cmd;
	assign q_ready = pop;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		phase_n = phase_q;
		op_n = op_q;
		addr_n = addr_q;
		data_n = data_q;
		shift_n = shift_q;
		bits_n = bits_q;
		wait_n = wait_q;
		rd_n = rd_q;
		res_n = '0;
		enter = 1'b0;
		finish = 1'b0;
		target = PH_IDLE;
		sel_op = op_q;
		sel_addr = addr_q;
		sel_data = data_q;

		if (pop && q_item.is_cmd) begin
			if (phase_q == PH_IDLE) begin
				op_n = q_item.opcode;
				addr_n = q_item.address;
				data_n = q_item.write_data;
				sel_op = q_item.opcode;
				sel_addr = q_item.address;
				sel_data = q_item.write_data;
				enter = 1'b1;
				target = is_program(q_item.opcode) ? PH_EN_FRAME : PH_CMD_FRAME;
			end
		end else if (tick) begin
			unique case (phase_q)
				PH_EN_FRAME, PH_CMD_FRAME, PH_DS_FRAME: begin
					res_n.chip_select = 1'b1;
					res_n.clock_pulse = 1'b1;
					res_n.serial_out = shift_q[23];
					shift_n = {shift_q[22:0], 1'b0};
					bits_n = bits_q - 5'd1;
					finish = (bits_n == 5'd0);
				end
				PH_RD_BITS: begin
					res_n.chip_select = 1'b1;
					res_n.clock_pulse = 1'b1;
					rd_n = {rd_q[6:0], q_item.serial_in};
					bits_n = bits_q - 5'd1;
					if (bits_n == 5'd0) begin
						res_n.read_valid = 1'b1;
						res_n.read_data = rd_n;
						finish = 1'b1;
					end
				end
				PH_EN_GAP, PH_CMD_GAP, PH_CMD_WAIT, PH_DS_GAP: begin
					wait_n = wait_q - WB'(1);
					finish = (wait_n == '0);
				end
				default: phase_n = PH_IDLE;
			endcase
			if (finish) begin
				enter = 1'b1;
				target = next_phase(phase_q, op_q);
			end
		end

		rphase = resolve(target, gap_zero, wait_zero, is_program(sel_op));
		if (enter) begin
			phase_n = rphase;
			unique case (rphase)
				PH_EN_FRAME: begin
					shift_n = {8'h02, 8'h60, 8'h00};
					bits_n = 5'd16;
				end
				PH_DS_FRAME: begin
					shift_n = {8'h02, 8'h00, 8'h00};
					bits_n = 5'd16;
				end
				PH_CMD_FRAME: begin
					shift_n = cmd_frame(sel_op, sel_addr, sel_data);
					bits_n = (sel_op == mecm_pkg::OP_WRITE || sel_op == mecm_pkg::OP_WRAL) ?
						5'd24 : 5'd16;
				end
				PH_RD_BITS: begin
					rd_n = 8'h00;
					bits_n = 5'd8;
				end
				PH_EN_GAP, PH_CMD_GAP, PH_DS_GAP: wait_n = gap_ticks;
				PH_CMD_WAIT: wait_n = wait_ticks;
				default: ;
			endcase
		end

		if (tick) begin
			res_n.busy_res = (phase_n != PH_IDLE);
			res_n.command_done = finish && (phase_n == PH_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q <= 3'd0;
			addr_q <= 7'd0;
			data_q <= 8'd0;
			shift_q <= 24'd0;
			bits_q <= 5'd0;
			wait_q <= '0;
			rd_q <= 8'd0;
			frame_gap_q <= mecm_pkg::FRAME_GAP_RESET;
			program_wait_q <= mecm_pkg::PROGRAM_WAIT_RESET;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			phase_q <= phase_n;
			op_q <= op_n;
			addr_q <= addr_n;
			data_q <= data_n;
			shift_q <= shift_n;
			bits_q <= bits_n;
			wait_q <= wait_n;
			rd_q <= rd_n;
			if (cfg_we && cfg_index == mecm_pkg::CFG_FRAME_GAP) begin
				frame_gap_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == mecm_pkg::CFG_PROGRAM_WAIT) begin
				program_wait_q <= cfg_wdata;
			end
			if (tick) begin
				res_valid_q <= 1'b1;
				res_q <= res_n;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/mecm_checker.sv
// port checks of the command master, bound to the top level
module mecm_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input mecm_pkg::res_item_t res
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// the serial clock only pulses while the memory is selected
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.chip_select == res.clock_pulse) &&
			(!res.serial_out || res.chip_select))
		else $error("line levels out of frame");

	// a read byte comes with a clocked, selected tick and read data is zero otherwise
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.read_valid ? (res.chip_select && !res.serial_out) :
			(res.read_data == 8'd0)))
		else $error("read byte outside a read bit");

	// the closing tick leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.command_done |-> !res.busy_res)
		else $error("done while still busy");

endmodule

bind microwire_eeprom_command_master mecm_checker u_mecm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res(res)
);
